// ----- hw/rtl/gbr_pkg.sv -----
// Shared widths, register codes, metadata type and kernel class lookup for the blur core.
package gbr_pkg;

  // Pixel and channel geometry
  localparam int PIX_W      = 8;
  localparam int CH_N       = 3;
  localparam int PX_W       = CH_N * PIX_W;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int IMGW_W     = 12;
  localparam int IMGH_W     = 13;
  localparam int GEO_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  // Weights are unsigned Q0.16
  localparam int WT_W   = 16;
  localparam int WT_N   = 6;
  localparam int FRAC_W = 16;
  localparam int CLS_W  = 3;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - CH_N * PIX_W - ROW_W - COL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults
  localparam int RADIUS_DEF    = 2;
  localparam int MAX_WIDTH_DEF = 2048;

  // Register reset values
  localparam logic [IMGW_W-1:0] IMG_W_RST = IMGW_W'(640);
  localparam logic [IMGH_W-1:0] IMG_H_RST = IMGH_W'(480);
  localparam logic [WT_W-1:0]   WT_RST [WT_N] = '{
    WT_W'(10713), WT_W'(7811), WT_W'(5696), WT_W'(3028), WT_W'(2208), WT_W'(856)
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_WEIGHT_CENTRE   = 3'd2,
    REG_WEIGHT_EDGE_ONE = 3'd3,
    REG_WEIGHT_DIAG_ONE = 3'd4,
    REG_WEIGHT_EDGE_TWO = 3'd5,
    REG_WEIGHT_KNIGHT   = 3'd6,
    REG_WEIGHT_CORNER   = 3'd7
  } cfg_reg_t;

  // Position and frame flag that travel with each pixel through the pipe
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  // Map a window offset to its distance class (unordered pair of magnitudes)
  function automatic logic [CLS_W-1:0] class_idx(input int dy, input int dx);
    int a;
    int b;
    int hi;
    int lo;
    logic [CLS_W-1:0] cls;
    a  = (dy < 0) ? -dy : dy;
    b  = (dx < 0) ? -dx : dx;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (hi == 0) begin
      cls = CLS_W'(0);
    end else if (hi == 1) begin
      cls = (lo == 0) ? CLS_W'(1) : CLS_W'(2);
    end else if (lo == 0) begin
      cls = CLS_W'(3);
    end else if (lo == 1) begin
      cls = CLS_W'(4);
    end else begin
      cls = CLS_W'(5);
    end
    return cls;
  endfunction

endpackage

// ----- hw/rtl/gaussian_blur_rgb_core.sv -----
// Each result passes the stage 1, window, class-sum, product and output registers in that order.
// Throughput: one pixel per cycle when not stalled; five register stages each take a new beat when
// downstream moves or the stage is empty, so the line-store port and the window shift set the pace.
// Results appear only for interior pixels; the other pixels update state and produce no beat.
// Reset (rst_n low, synchronous) clears counters, window, valids and reloads default registers;
// the line stores are not cleared and need no clearing pass.
module gaussian_blur_rgb_core #(
  parameter int RADIUS    = gbr_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gbr_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: red_out [7:0], green_out [15:8], blue_out [23:16],
  //            centre_row [35:24], centre_col [46:36], zero pad [47]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gbr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbr_pkg::*;

  localparam int KSIZE  = 2 * RADIUS + 1;
  localparam int NLINES = 2 * RADIUS;
  localparam int SLOT_W = $clog2(NLINES);
  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int NCLS   = (RADIUS + 1) * (RADIUS + 2) / 2;
  localparam int CSUM_W = PIX_W + $clog2(4 * RADIUS);
  localparam int PROD_W = CSUM_W + WT_W;
  localparam int ACC_W  = PROD_W + $clog2(NCLS);

  // Configuration registers
  logic [IMGW_W-1:0] img_w_r;
  logic [IMGH_W-1:0] img_h_r;
  logic [WT_W-1:0]   wts_r [WT_N];

  // Raster counters
  logic [CNT_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [CNT_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;

  logic [GEO_W-1:0] w_eff;
  logic [GEO_W-1:0] h_eff;
  logic [GEO_W-1:0] col_ext;
  logic [GEO_W-1:0] row_ext;
  logic             line_end;
  logic             frame_last;
  logic             emit;
  meta_t            meta_in;

  // Stage handshake
  logic in_fire;
  logic rdy2, rdy3, rdy4, rdy5;
  logic s1_go;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // Stage 1 payload
  logic [PX_W-1:0]   s1_pix_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_emit_r;
  meta_t             s1_meta_r;
  logic [PX_W-1:0]   rd_q [NLINES];

  // Window and later stages
  logic [PX_W-1:0]   win_r [KSIZE][KSIZE];
  meta_t             s2_meta_r, s3_meta_r, s4_meta_r, out_meta_r;
  logic [CSUM_W-1:0] csum [CH_N][NCLS];
  logic [CSUM_W-1:0] cs_r [CH_N][NCLS];
  logic [PROD_W-1:0] prod_r [CH_N][NCLS];
  logic [ACC_W-1:0]  acc [CH_N];
  logic [PIX_W-1:0]  sat [CH_N];
  logic [PIX_W-1:0]  out_pix_r [CH_N];

  // Configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
      for (int k = 0; k < WT_N; k++) begin
        wts_r[k] <= WT_RST[k];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:     img_w_r  <= cfg_data[IMGW_W-1:0];
        REG_IMAGE_HEIGHT:    img_h_r  <= cfg_data[IMGH_W-1:0];
        REG_WEIGHT_CENTRE:   wts_r[0] <= cfg_data[WT_W-1:0];
        REG_WEIGHT_EDGE_ONE: wts_r[1] <= cfg_data[WT_W-1:0];
        REG_WEIGHT_DIAG_ONE: wts_r[2] <= cfg_data[WT_W-1:0];
        REG_WEIGHT_EDGE_TWO: wts_r[3] <= cfg_data[WT_W-1:0];
        REG_WEIGHT_KNIGHT:   wts_r[4] <= cfg_data[WT_W-1:0];
        REG_WEIGHT_CORNER:   wts_r[5] <= cfg_data[WT_W-1:0];
        default:             img_w_r  <= img_w_r;
      endcase
    end
  end

  // Clamp geometry and decide line end, frame end and emission
  always_comb begin
    if (img_w_r == '0) begin
      w_eff = GEO_W'(1);
    end else if (GEO_W'(img_w_r) > GEO_W'(MAX_WIDTH)) begin
      w_eff = GEO_W'(MAX_WIDTH);
    end else begin
      w_eff = GEO_W'(img_w_r);
    end
    if (img_h_r == '0) begin
      h_eff = GEO_W'(1);
    end else if (GEO_W'(img_h_r) > GEO_W'(MAX_HEIGHT)) begin
      h_eff = GEO_W'(MAX_HEIGHT);
    end else begin
      h_eff = GEO_W'(img_h_r);
    end
    col_ext    = GEO_W'(col_r);
    row_ext    = GEO_W'(row_r);
    line_end   = (col_ext + GEO_W'(1)) >= w_eff;
    frame_last = line_end && ((row_ext + GEO_W'(1)) >= h_eff);
    emit       = (col_ext < w_eff) && (row_ext < h_eff) &&
                 (col_ext >= GEO_W'(NLINES)) && (row_ext >= GEO_W'(NLINES));
    meta_in.row  = ROW_W'(row_ext - GEO_W'(RADIUS));
    meta_in.col  = COL_W'(col_ext - GEO_W'(RADIUS));
    meta_in.last = frame_last;
    if (frame_last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (line_end) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + CNT_W'(1);
      row_nxt = row_r;
    end
  end

  // Ready chain: a stage takes a beat when empty or when it hands its own beat on
  assign rdy5      = !out_valid_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign in_tready = !v1_r || rdy2;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_go     = v1_r && rdy2;

  // Advance counters on each accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store banks, one per line: all read old data at the column; the row's bank writes the pixel
  for (genvar k = 0; k < NLINES; k++) begin : g_bank
    logic [PX_W-1:0] mem [MAX_WIDTH];
    logic [PX_W-1:0] bank_rd_r;

    always_ff @(posedge clk) begin
      if (in_fire) begin
        if (row_r[SLOT_W-1:0] == SLOT_W'(k)) begin
          mem[col_r] <= in_tdata[PX_W-1:0];
        end
        bank_rd_r <= mem[col_r];
      end
    end

    assign rd_q[k] = bank_rd_r;
  end

  // Stage 1: hold the pixel and its position until the window takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_tdata[PX_W-1:0];
      s1_slot_r <= row_r[SLOT_W-1:0];
      s1_emit_r <= emit;
      s1_meta_r <= meta_in;
    end
  end

  // Stage 2: shift the window one column and load the new column; drop non-interior beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      if (rdy2) begin
        v2_r <= v1_r && s1_emit_r;
      end
      if (s1_go) begin
        for (int i = 0; i < KSIZE; i++) begin
          for (int j = 0; j < KSIZE - 1; j++) begin
            win_r[i][j] <= win_r[i][j+1];
          end
        end
        for (int i = 0; i < NLINES; i++) begin
          win_r[i][KSIZE-1] <= rd_q[SLOT_W'(s1_slot_r + SLOT_W'(i))];
        end
        win_r[NLINES][KSIZE-1] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // Pre-add pixels that share a weight
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      for (int k = 0; k < NCLS; k++) begin
        csum[c][k] = '0;
      end
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE; j++) begin
          csum[c][class_idx(i - RADIUS, j - RADIUS)] =
            csum[c][class_idx(i - RADIUS, j - RADIUS)] +
            CSUM_W'(win_r[i][j][c*PIX_W +: PIX_W]);
        end
      end
    end
  end

  // Stage 3: class sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      cs_r      <= csum;
      s3_meta_r <= s2_meta_r;
    end
  end

  // Stage 4: weight each class sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int c = 0; c < CH_N; c++) begin
        for (int k = 0; k < NCLS; k++) begin
          prod_r[c][k] <= PROD_W'(cs_r[c][k]) * PROD_W'(wts_r[k]);
        end
      end
      s4_meta_r <= s3_meta_r;
    end
  end

  // Sum the products, drop the fraction and saturate
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      acc[c] = '0;
      for (int k = 0; k < NCLS; k++) begin
        acc[c] = acc[c] + ACC_W'(prod_r[c][k]);
      end
      if (acc[c][ACC_W-1:FRAC_W+PIX_W] != '0) begin
        sat[c] = '1;
      end else begin
        sat[c] = acc[c][FRAC_W+PIX_W-1:FRAC_W];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_pix_r  <= sat;
      out_meta_r <= s4_meta_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_meta_r.last;
  assign out_tdata  = {OUT_PAD_W'(0), out_meta_r.col, out_meta_r.row,
                       out_pix_r[2], out_pix_r[1], out_pix_r[0]};

endmodule

// ----- hw/rtl/gbr_checker.sv -----
// Port-level assertions for the blur core and the bind that attaches them.
module gbr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [gbr_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gbr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbr_pkg::*;

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata) ^ cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // With the output free the whole pipe drains, so input must be ready
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while output side is free");

  // Reset empties the output register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // No beat can reach the output directly after reset release, as the pipe registers start empty
  a_rst_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> !out_tvalid)
    else $error("result appeared faster than pipeline latency");

endmodule

bind gaussian_blur_rgb_core gbr_checker u_gbr_checker (.*);

// ----- verif/gaussian_blur_rgb_core_tb.sv -----
// Self-checking testbench for the 5x5 RGB Gaussian blur core: directed frame, wide frame, random frames.
`timescale 1ns / 100ps

module gaussian_blur_rgb_core_tb;
  import gbr_pkg::*;

  // Worst run is near 1.7k pixels; this limit leaves ample headroom
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SETTLE_CYC   = 8;
  localparam int MAX_ERR_SHOW = 10;

  // One filtered pixel as it leaves the core
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } blur_px_t;

  // Directed stimulus row, with an optional hand-written result
  typedef struct packed {
    logic [23:0] pix;
    logic        check;
    blur_px_t    want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gaussian_blur_rgb_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Blur predictor state: registers, line memory, window, raster position
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [15:0] wt_reg [6];
  bit   [23:0] line_mem [4][2048];
  bit   [23:0] win [5][5];
  int          col_cnt = 0;
  int          row_cnt = 0;

  cfg_reg_t wt_regs [6] = '{REG_WEIGHT_CENTRE, REG_WEIGHT_EDGE_ONE, REG_WEIGHT_DIAG_ONE,
                            REG_WEIGHT_EDGE_TWO, REG_WEIGHT_KNIGHT, REG_WEIGHT_CORNER};

  blur_px_t blur_due [$];
  int       fail_cnt = 0;
  int       cycle_cnt = 0;
  int       in_mode = 0;
  int       out_mode = 0;
  int       safe_w = 0;
  int       random_pixels = 0;
  dir_row_t dir_table [25];

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("gaussian_blur_rgb_core_tb: FAIL");
      $finish;
    end
  end

  // Wait before a beat: none, uniform 0..18, or mostly back to back
  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(18, 0);
      default: return ($urandom_range(7, 0) == 0) ? $urandom_range(18, 1) : 0;
    endcase
  endfunction

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // Weight by squared distance from the centre tap
  function automatic logic [15:0] tap_weight(input int d2);
    case (d2)
      0: return wt_reg[0];
      1: return wt_reg[1];
      2: return wt_reg[2];
      4: return wt_reg[3];
      5: return wt_reg[4];
      default: return wt_reg[5];
    endcase
  endfunction

  // Weighted window sum for one color lane, drop 16 fraction bits, clip at 255
  function automatic logic [7:0] blur_channel(input int lane);
    longint unsigned acc;
    int i;
    int j;
    acc = 0;
    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 5; j++) begin
        acc += 64'(win[i][j][lane*8 +: 8]) * 64'(tap_weight((i-2)*(i-2) + (j-2)*(j-2)));
      end
    end
    acc = acc >> 16;
    return (acc > 255) ? 8'hFF : acc[7:0];
  endfunction

  // Advance the blur predictor by one pixel; return 1 when a result is due
  function automatic bit model_pixel(input logic [23:0] pix, output blur_px_t res);
    int  w;
    int  h;
    int  c;
    int  r;
    int  i;
    int  j;
    bit  line_done;
    bit  frame_done;
    bit  emit;
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    r = row_cnt;
    res = '0;
    // shift window left, load new column from the line memory
    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 4; j++) win[i][j] = win[i][j+1];
    end
    for (i = 0; i < 4; i++) win[i][4] = line_mem[(r + i) % 4][c];
    win[4][4] = pix;
    line_mem[r % 4][c] = pix;
    line_done  = (c + 1 >= w);
    frame_done = line_done && (r + 1 >= h);
    emit = (c < w) && (r < h) && (c >= 4) && (r >= 4);
    if (emit) begin
      res.red   = blur_channel(0);
      res.green = blur_channel(1);
      res.blue  = blur_channel(2);
      res.row   = 12'(r - 2);
      res.col   = 11'(c - 2);
      res.last  = frame_done;
    end
    // advance raster position
    if (frame_done) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (line_done) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
    end
    return emit;
  endfunction

  // Pixels still needed to close the current frame under the present geometry
  function automatic int pixels_left();
    int w;
    int h;
    int n;
    w = eff_width();
    h = eff_height();
    n = (col_cnt >= w) ? 1 : w - col_cnt;
    if (row_cnt + 1 < h) n += (h - 1 - row_cnt) * w;
    return n;
  endfunction

  function automatic int pick_style();
    int d;
    d = $urandom_range(19, 0);
    if (d < 9) return 1;
    if (d < 14) return 2;
    if (d < 17) return 3;
    return 4;
  endfunction

  function automatic logic [23:0] rand_pixel();
    logic [23:0] p;
    int k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(9, 0))
        0: p[k*8 +: 8] = 8'h00;
        1: p[k*8 +: 8] = 8'hFF;
        default: p[k*8 +: 8] = 8'($urandom());
      endcase
    end
    return p;
  endfunction

  // Write one register beat; the caller drops cfg_valid after the batch
  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = val[11:0];
      REG_IMAGE_HEIGHT: height_reg = val[12:0];
      default:          wt_reg[idx - REG_WEIGHT_CENTRE] = val;
    endcase
  endtask

  // Drain the core, then load geometry and/or a weight set
  task automatic reconfigure(input int new_w, input int new_h, input bit set_w,
                             input bit set_h, input int style);
    logic [15:0] v;
    int k;
    while (blur_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (set_w) cfg_write(REG_IMAGE_WIDTH, {4'($urandom_range(15, 0)), 12'(new_w)});
    if (set_h) cfg_write(REG_IMAGE_HEIGHT, {3'($urandom_range(7, 0)), 13'(new_h)});
    if (style != 0) begin
      for (k = 0; k < 6; k++) begin
        case (style)
          1: v = 16'($urandom_range(4095, 0));
          2: v = 16'($urandom());
          3: v = 16'hFFFF;
          default: v = 16'h0000;
        endcase
        cfg_write(wt_regs[k], v);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Send one pixel beat and log what the core owes for it
  task automatic push_pixel(input logic [23:0] pix, input bit typed, input blur_px_t typed_res);
    int gap;
    blur_px_t res;
    gap = draw_wait(in_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (model_pixel(pix, res)) blur_due.push_back(typed ? typed_res : res);
  endtask

  // Send n random pixels, then drop in_tvalid and idle the input
  task automatic feed(input int n);
    int k;
    for (k = 0; k < n; k++) push_pixel(rand_pixel(), 1'b0, '0);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: stall at random, check each beat against the oldest prediction
  always @(posedge clk) begin : rx_side
    blur_px_t got;
    blur_px_t want;
    int stall_left;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
             out_tdata[35:24], out_tdata[46:36], out_tlast};
      if (blur_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_ERR_SHOW)
          $display("%0t: unexpected beat row=%0d col=%0d", $realtime, got.row, got.col);
      end else begin
        want = blur_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= MAX_ERR_SHOW) begin
            $display("%0t: mismatch want rgb=%h/%h/%h row=%0d col=%0d last=%b", $realtime,
                     want.red, want.green, want.blue, want.row, want.col, want.last);
            $display("%0t:          got  rgb=%h/%h/%h row=%0d col=%0d last=%b", $realtime,
                     got.red, got.green, got.blue, got.row, got.col, got.last);
          end
        end
      end
      stall_left = draw_wait(out_mode);
      if (stall_left > 0) out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int k;
    int n;
    int nw;
    int nh;
    int bound;
    bit at_start;
    bit full;
    width_reg  = IMG_W_RST;
    height_reg = IMG_H_RST;
    wt_reg     = WT_RST;

    // Hold reset, then release
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest legal frame, reset weights, corners black: every lane clips at 255
    dir_table = '{
      '{24'h000000, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0}, '{24'hFFFFFF, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 12'd2, 11'd2, 1'b1}}
    };
    reconfigure(5, 5, 1'b1, 1'b1, 0);
    for (k = 0; k < 25; k++) push_pixel(dir_table[k].pix, dir_table[k].check, dir_table[k].want);
    in_tvalid <= 1'b0;
    safe_w = 5;

    // Oversized geometry clamps to 2048 x 4096; shrink mid-frame so the frame closes early
    in_mode  = 2;
    out_mode = $urandom_range(2, 0);
    reconfigure(4095, 8191, 1'b1, 1'b1, pick_style());
    feed(300);
    reconfigure(5, 8, 1'b1, 1'b1, 1);
    feed(pixels_left());

    // Random frames, partial frames and mid-frame geometry changes
    while (random_pixels < RANDOM_ITEMS) begin
      in_mode  = $urandom_range(2, 0);
      out_mode = $urandom_range(2, 0);
      at_start = (col_cnt == 0) && (row_cnt == 0);
      if (at_start) begin
        nw = ($urandom_range(6, 0) == 0) ? $urandom_range(4, 0) : $urandom_range(16, 5);
        nh = ($urandom_range(6, 0) == 0) ? $urandom_range(4, 0) : $urandom_range(10, 5);
        reconfigure(nw, nh, 1'b1, 1'b1, ($urandom_range(9, 0) < 7) ? pick_style() : 0);
      end else if ($urandom_range(9, 0) < 6) begin
        // widen only over columns every line slot already holds
        bound = (safe_w > eff_width()) ? safe_w : eff_width();
        reconfigure($urandom_range(bound, 0), $urandom_range(12, 0), 1'($urandom_range(1, 0)),
                    1'($urandom_range(1, 0)), ($urandom_range(9, 0) < 3) ? pick_style() : 0);
      end
      n = pixels_left();
      full = at_start;
      if ($urandom_range(4, 0) == 0) begin
        n = $urandom_range(n, 1);
        full = 1'b0;
      end
      feed(n);
      random_pixels += n;
      if (full && eff_height() >= 4 && eff_width() > safe_w) safe_w = eff_width();
    end

    // Drain and report
    while (blur_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("gaussian_blur_rgb_core_tb: PASS");
    end else begin
      $display("gaussian_blur_rgb_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- gaussian_blur_rgb_core.f -----
hw/rtl/gbr_pkg.sv
hw/rtl/gaussian_blur_rgb_core.sv
hw/rtl/gbr_checker.sv
verif/gaussian_blur_rgb_core_tb.sv
